// ----- rtl/aad_pkg.sv -----
package aad_pkg;

	// field widths
	localparam int unsigned SAMPLE_W   = 12;
	localparam int unsigned JOY_W      = 16;
	localparam int unsigned DRIVE_W    = 15;
	localparam int unsigned Q15_W      = 15;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 15;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADBAND   = 2'd0,
		CFG_READY_THR  = 2'd1,
		CFG_UP_SPEED   = 2'd2,
		CFG_MAX_HEIGHT = 2'd3
	} cfg_idx_t;

	// configuration reset values
	localparam logic [Q15_W-1:0]    DEADBAND_RST   = 15'd4915;
	localparam logic [SAMPLE_W-1:0] READY_THR_RST  = 12'd2212;
	localparam logic [Q15_W-1:0]    UP_SPEED_RST   = 15'd24576;
	localparam logic [SAMPLE_W-1:0] MAX_HEIGHT_RST = 12'd2949;

	// largest positive drive after halving
	localparam logic signed [17:0] DRIVE_MAX = 18'sd16383;

	typedef struct packed {
		logic [SAMPLE_W-1:0]     angle_sample;
		logic signed [JOY_W-1:0] joystick_axis;
		logic                    override_on;
		logic                    grip_button;
	} in_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      brake_engaged;
		logic                      gripper_closed;
		logic                      ready_position;
		logic [SAMPLE_W-1:0]       average_angle;
	} out_t;

	// control from the pipeline to the ring averager
	typedef struct packed {
		logic                push;
		logic [SAMPLE_W-1:0] sample;
	} avg_req_t;

endpackage

// ----- rtl/aad_avg.sv -----
module aad_avg #(
	parameter int unsigned AVG_DEPTH = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  aad_pkg::avg_req_t                             req,
	output logic [aad_pkg::SAMPLE_W+$clog2(AVG_DEPTH)-1:0] sum
);

	localparam int unsigned SUM_W    = aad_pkg::SAMPLE_W + $clog2(AVG_DEPTH);
	localparam int unsigned PTR_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int unsigned PTR_INIT = 1 % AVG_DEPTH;
	localparam int unsigned PTR_LAST = AVG_DEPTH - 1;

	logic [aad_pkg::SAMPLE_W-1:0] ring_mem [AVG_DEPTH];
	logic [aad_pkg::SAMPLE_W-1:0] rd_q;
	logic [aad_pkg::SAMPLE_W-1:0] first_q;
	logic [PTR_W-1:0]             ptr_q;
	logic [PTR_W-1:0]             ptr_nxt;
	logic [PTR_W-1:0]             rd_addr;
	logic                         primed_q;
	logic                         wrapped_q;
	logic [SUM_W-1:0]             sum_q;
	logic [SUM_W-1:0]             base;
	logic [aad_pkg::SAMPLE_W-1:0] old_val;
	logic [SUM_W:0]               sum_nxt;

	// next slot to overwrite
	assign ptr_nxt = (ptr_q == PTR_W'(PTR_LAST)) ? '0 : ptr_q + PTR_W'(1);
	assign rd_addr = req.push ? ptr_nxt : ptr_q;

	// first sample stands for every slot not yet written
	always_comb begin
		if (!primed_q) begin
			base    = SUM_W'(AVG_DEPTH) * SUM_W'(req.sample);
			old_val = req.sample;
		end else begin
			base    = sum_q;
			old_val = wrapped_q ? rd_q : first_q;
		end
		sum_nxt = {1'b0, base} + (SUM_W+1)'(req.sample) - (SUM_W+1)'(old_val);
	end

	// ring memory with prefetched read of the next slot
	always_ff @(posedge clk) begin
		if (req.push) begin
			ring_mem[ptr_q] <= req.sample;
		end
		if (req.push && (ptr_nxt == ptr_q)) begin
			rd_q <= req.sample;
		end else begin
			rd_q <= ring_mem[rd_addr];
		end
		if (req.push && !primed_q) begin
			first_q <= req.sample;
		end
	end

	// pointer, fill state and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= PTR_W'(PTR_INIT);
			primed_q  <= 1'b0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (req.push) begin
			ptr_q    <= ptr_nxt;
			primed_q <= 1'b1;
			sum_q    <= sum_nxt[SUM_W-1:0];
			if (ptr_q == '0) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	assign sum = sum_q;

endmodule

// ----- rtl/arm_drive_with_averaged_angle.sv -----
// Arm drive with averaged angle sensor.
// Input channel in_valid/in_stall/in_data carries one control tick: angle
// sample, joystick axis, override and gripper press. Output channel
// out_valid/out_stall/out_data returns one drive request per tick with
// brake, gripper, ready flag and the ring average of the last AVG_DEPTH samples.
// Throughput: one request per cycle while out_stall is low; the four-stage
// pipeline (input register, deadband/ring update, reciprocal multiply for the
// average, result register) has no shared unit, and the running sum turns the
// average into one add/subtract plus one constant multiply.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data), taken
// whenever cfg_write is high; write it only while the pipeline is empty.
// Reset clears the pipeline, the running sum and the gripper state, resets the
// ring pointer and loads default configuration; the first sample after reset
// stands for the whole ring. When out_stall is high the result register holds
// and each stage keeps taking requests until it is full, then in_stall rises.
module arm_drive_with_averaged_angle #(
	parameter int unsigned AVG_DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  aad_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output aad_pkg::out_t                      out_data,
	input  logic                               cfg_write,
	input  logic [aad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aad_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned SUM_W  = aad_pkg::SAMPLE_W + $clog2(AVG_DEPTH);
	localparam int unsigned RCP_SH = SUM_W + $clog2(AVG_DEPTH);
	localparam int unsigned RCP_M  = ((32'd1 << RCP_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
	localparam int unsigned PROD_W = 2 * SUM_W + 1;

	// configuration registers
	logic [aad_pkg::Q15_W-1:0]    deadband_q;
	logic [aad_pkg::SAMPLE_W-1:0] ready_thr_q;
	logic [aad_pkg::Q15_W-1:0]    up_speed_q;
	logic [aad_pkg::SAMPLE_W-1:0] max_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= aad_pkg::DEADBAND_RST;
			ready_thr_q  <= aad_pkg::READY_THR_RST;
			up_speed_q   <= aad_pkg::UP_SPEED_RST;
			max_height_q <= aad_pkg::MAX_HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				aad_pkg::CFG_DEADBAND:   deadband_q   <= cfg_data[aad_pkg::Q15_W-1:0];
				aad_pkg::CFG_READY_THR:  ready_thr_q  <= cfg_data[aad_pkg::SAMPLE_W-1:0];
				aad_pkg::CFG_UP_SPEED:   up_speed_q   <= cfg_data[aad_pkg::Q15_W-1:0];
				aad_pkg::CFG_MAX_HEIGHT: max_height_q <= cfg_data[aad_pkg::SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline valids and per-stage enables
	logic v1_q, v2_q, v3_q, v4_q;
	logic en1, en2, en3, en4;

	assign en4      = !v4_q || !out_stall;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en1) v1_q <= in_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
		end
	end

	// stage 1: input register
	aad_pkg::in_t in_s1;

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// ring averager, updated as a request leaves stage 1
	aad_pkg::avg_req_t avg_req;
	logic [SUM_W-1:0]  sum;

	assign avg_req.push   = en2 && v1_q;
	assign avg_req.sample = in_s1.angle_sample;

	aad_avg #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_avg (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (avg_req),
		.sum   (sum)
	);

	// joystick path: negate, deadband, halve toward zero, saturate
	logic signed [16:0] joy_neg;
	logic [16:0]        joy_mag;
	logic signed [17:0] db_s;
	logic signed [17:0] shrunk;
	logic signed [17:0] rounded;
	logic signed [17:0] halved;
	logic signed [aad_pkg::DRIVE_W-1:0] joy_drive;

	always_comb begin
		joy_neg = -{in_s1.joystick_axis[aad_pkg::JOY_W-1], in_s1.joystick_axis};
		joy_mag = joy_neg[16] ? 17'(-joy_neg) : joy_neg;
		db_s    = $signed({3'b000, deadband_q});
		if (joy_mag < {2'b00, deadband_q}) begin
			shrunk = '0;
		end else if (joy_neg > 17'sd0) begin
			shrunk = 18'(joy_neg) - db_s;
		end else if (joy_neg < 17'sd0) begin
			shrunk = 18'(joy_neg) + db_s;
		end else begin
			shrunk = '0;
		end
		rounded = shrunk + $signed({17'd0, shrunk[17]});
		halved  = rounded >>> 1;
		if (halved > aad_pkg::DRIVE_MAX) begin
			joy_drive = aad_pkg::DRIVE_MAX[aad_pkg::DRIVE_W-1:0];
		end else begin
			joy_drive = halved[aad_pkg::DRIVE_W-1:0];
		end
	end

	// override path: fixed upward speed after deadband and halving
	logic [aad_pkg::Q15_W-1:0]          up_diff;
	logic signed [aad_pkg::DRIVE_W-1:0] up_drive;

	always_comb begin
		up_diff = up_speed_q - deadband_q;
		if (up_speed_q < deadband_q) begin
			up_drive = '0;
		end else begin
			up_drive = $signed({1'b0, up_diff[aad_pkg::Q15_W-1:1]});
		end
	end

	// stage 2: gripper toggle and both drive candidates
	logic                               grip_q;
	logic                               grip_nxt;
	logic signed [aad_pkg::DRIVE_W-1:0] joy_drive_s2;
	logic signed [aad_pkg::DRIVE_W-1:0] up_drive_s2;
	logic                               ovr_s2;
	logic                               grip_s2;

	assign grip_nxt = grip_q ^ in_s1.grip_button;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grip_q <= 1'b0;
		end else if (avg_req.push) begin
			grip_q <= grip_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (avg_req.push) begin
			joy_drive_s2 <= joy_drive;
			up_drive_s2  <= up_drive;
			ovr_s2       <= in_s1.override_on;
			grip_s2      <= grip_nxt;
		end
	end

	// stage 3: average by reciprocal multiply, exact for every sum
	logic [SUM_W:0]                     rcp;
	logic [PROD_W-1:0]                  prod;
	logic [aad_pkg::SAMPLE_W-1:0]       avg_s3;
	logic signed [aad_pkg::DRIVE_W-1:0] joy_drive_s3;
	logic signed [aad_pkg::DRIVE_W-1:0] up_drive_s3;
	logic                               ovr_s3;
	logic                               grip_s3;

	assign rcp  = RCP_M[SUM_W:0];
	assign prod = PROD_W'(sum) * PROD_W'(rcp);

	always_ff @(posedge clk) begin
		if (en3 && v2_q) begin
			avg_s3       <= prod[RCP_SH +: aad_pkg::SAMPLE_W];
			joy_drive_s3 <= joy_drive_s2;
			up_drive_s3  <= up_drive_s2;
			ovr_s3       <= ovr_s2;
			grip_s3      <= grip_s2;
		end
	end

	// stage 4: ready compare, height limit, result register
	logic                               ready;
	logic signed [aad_pkg::DRIVE_W-1:0] sel_drive;
	logic signed [aad_pkg::DRIVE_W-1:0] fin_drive;
	aad_pkg::out_t                      out_s4;

	always_comb begin
		ready = ovr_s3 && (avg_s3 >= ready_thr_q);
		if (ovr_s3) begin
			sel_drive = ready ? '0 : up_drive_s3;
		end else begin
			sel_drive = joy_drive_s3;
		end
		if ((avg_s3 >= max_height_q) && !sel_drive[aad_pkg::DRIVE_W-1]) begin
			fin_drive = '0;
		end else begin
			fin_drive = sel_drive;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v3_q) begin
			out_s4.drive          <= fin_drive;
			out_s4.brake_engaged  <= (fin_drive == '0);
			out_s4.gripper_closed <= grip_s3;
			out_s4.ready_position <= ready;
			out_s4.average_angle  <= avg_s3;
		end
	end

	assign out_valid = v4_q;
	assign out_data  = out_s4;

endmodule
